>>> hw/rtl/assert_macros.svh
// assertion macros shared by the rtl files of the request line parser
// expects clk and arst_n in the scope where a macro is used
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked outside reset
`define HRLP_ASSERT_IMP(name, pre, post) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error("hrlp assertion failed");

// next-cycle implication, checked outside reset
`define HRLP_ASSERT_NXT(name, pre, post) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error("hrlp assertion failed");

`endif

>>> hw/rtl/hrlp_pkg.sv
// types, constants and helper functions of the request line parser
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps
`default_nettype none

package hrlp_pkg;

	localparam int HEADER_BYTES = 1024;
	localparam int POS_W        = $clog2(HEADER_BYTES + 1);
	localparam int OFF_W        = 10;
	localparam int HLEN_W       = 11;
	localparam int NUM_METHODS  = 9;
	localparam int NAME_CHARS   = 7;

	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_QMARK = 8'h3F;
	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_TAB   = 8'h09;

	localparam logic [2:0] ED_IDLE = 3'd0;
	localparam logic [2:0] ED_CR2  = 3'd3;
	localparam logic [2:0] ED_DONE = 3'd4;

	typedef enum logic [3:0] {
		M_GET     = 4'd0,
		M_POST    = 4'd1,
		M_HEAD    = 4'd2,
		M_PUT     = 4'd3,
		M_DELETE  = 4'd4,
		M_TRACE   = 4'd5,
		M_OPTIONS = 4'd6,
		M_CONNECT = 4'd7,
		M_PATCH   = 4'd8,
		M_UNKNOWN = 4'd9
	} method_t;

	typedef enum logic [2:0] {
		PH_METHOD = 3'd0,
		PH_SP1    = 3'd1,
		PH_URL    = 3'd2,
		PH_SP2    = 3'd3,
		PH_PROTO  = 3'd4,
		PH_REST   = 3'd5
	} phase_t;

	localparam logic [8*NAME_CHARS-1:0] METHOD_STR [NUM_METHODS] = '{
		"GET", "POST", "HEAD", "PUT", "DELETE", "TRACE", "OPTIONS", "CONNECT", "PATCH"
	};
	localparam logic [2:0] METHOD_LEN [NUM_METHODS] = '{
		3'd3, 3'd4, 3'd4, 3'd3, 3'd6, 3'd5, 3'd7, 3'd7, 3'd5
	};

	typedef struct packed {
		logic [NUM_METHODS-1:0] alive;
		logic                   found;
		method_t                idx;
	} hrlp_match_t;

	typedef struct packed {
		logic               ovf;
		method_t            method;
		phase_t             phase;
		logic [OFF_W-1:0]   url_begin;
		logic [POS_W-1:0]   url_len;
		logic               slash;
		logic               qseen;
		logic [POS_W-1:0]   qoff;
		logic [OFF_W-1:0]   proto_begin;
		logic [POS_W-1:0]   proto_len;
		logic [HLEN_W-1:0]  hlen;
	} hrlp_snap_t;

	function automatic logic is_ws(input logic [7:0] b);
		return (b == CH_SPACE) || (b >= CH_TAB && b <= CH_CR);
	endfunction

	function automatic logic [7:0] method_char(input int unsigned idx, input logic [2:0] pos);
		int sh;
		sh = 8 * (int'(METHOD_LEN[idx]) - 1 - int'(pos));
		if (sh < 0) begin
			return 8'h00;
		end
		return METHOD_STR[idx][sh +: 8];
	endfunction

endpackage

`default_nettype wire

>>> hw/rtl/hrlp_method_match.sv
// method name matcher: narrows the candidate set by one byte
// uses hrlp_pkg for the name table
`timescale 1ns / 1ps
`default_nettype none

module hrlp_method_match (
	input  logic [hrlp_pkg::NUM_METHODS-1:0] cand,
	input  logic                             pos_ok,
	input  logic [2:0]                       pos,
	input  logic [7:0]                       rx_byte,
	output hrlp_pkg::hrlp_match_t            mt
);
	import hrlp_pkg::*;

	logic [NUM_METHODS-1:0] hit;
	logic [NUM_METHODS-1:0] last;

	always_comb begin
		for (int i = 0; i < NUM_METHODS; i++) begin
			hit[i]  = cand[i] && pos_ok && (pos < METHOD_LEN[i])
				&& (method_char(i, pos) == rx_byte);
			last[i] = hit[i] && (({1'b0, pos} + 4'd1) == {1'b0, METHOD_LEN[i]});
		end
	end

	// lowest index wins when several names complete
	always_comb begin
		mt.alive = hit;
		mt.found = |last;
		mt.idx   = M_UNKNOWN;
		for (int i = NUM_METHODS - 1; i >= 0; i--) begin
			if (last[i]) begin
				mt.idx = method_t'(4'(i));
			end
		end
	end

endmodule

`default_nettype wire

>>> hw/rtl/hrlp_parser.sv
// per-byte parse state: position, phase, method, url and protocol tokens
// uses hrlp_pkg and hrlp_method_match
`timescale 1ns / 1ps
`default_nettype none

module hrlp_parser (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 take,
	input  logic [7:0]           rx_byte,
	output logic                 res,
	output hrlp_pkg::hrlp_snap_t snap
);
	import hrlp_pkg::*;

	logic [POS_W-1:0]       pos_q;
	phase_t                 phase_q, phase_n, eff_phase;
	logic [NUM_METHODS-1:0] cand_q, cand_n;
	method_t                method_q, method_n;
	logic [2:0]             ed_q, ed_n;
	logic [OFF_W-1:0]       url_begin_q, url_begin_n;
	logic [POS_W-1:0]       url_len_q, url_len_n;
	logic                   slash_q, slash_n;
	logic                   qseen_q, qseen_n;
	logic [POS_W-1:0]       qoff_q, qoff_n;
	logic [OFF_W-1:0]       proto_begin_q, proto_begin_n;
	logic [POS_W-1:0]       proto_len_q, proto_len_n;
	logic                   ws, scan, done, ovf;
	hrlp_match_t            mt;

	hrlp_method_match u_match (
		.cand    (cand_q),
		.pos_ok  (pos_q < POS_W'(8)),
		.pos     (pos_q[2:0]),
		.rx_byte (rx_byte),
		.mt      (mt)
	);

	assign ws = is_ws(rx_byte);

	// next state
	always_comb begin
		phase_n       = phase_q;
		cand_n        = cand_q;
		method_n      = method_q;
		url_begin_n   = url_begin_q;
		url_len_n     = url_len_q;
		slash_n       = slash_q;
		qseen_n       = qseen_q;
		qoff_n        = qoff_q;
		proto_begin_n = proto_begin_q;
		proto_len_n   = proto_len_q;
		eff_phase     = phase_q;
		scan          = 1'b0;

		case (ed_q)
			3'd1, ED_CR2: ed_n = (rx_byte == CH_LF) ? ed_q + 3'd1 : ED_IDLE;
			default:      ed_n = (rx_byte == CH_CR && ed_q < ED_CR2) ? ed_q + 3'd1 : ED_IDLE;
		endcase

		if (phase_q == PH_METHOD) begin
			cand_n = mt.alive;
			if (mt.found) begin
				method_n = mt.idx;
				phase_n  = PH_SP1;
			end else if (mt.alive == '0) begin
				method_n = M_UNKNOWN;
				scan     = 1'b1;
				if (pos_q == '0) begin
					eff_phase = PH_SP1;
				end else begin
					eff_phase   = PH_URL;
					url_begin_n = '0;
					url_len_n   = pos_q;
					slash_n     = 1'b0;
					qseen_n     = 1'b0;
					qoff_n      = '0;
				end
			end
		end else begin
			scan = 1'b1;
		end

		if (scan) begin
			phase_n = eff_phase;
			case (eff_phase)
				PH_SP1: begin
					if (!ws) begin
						url_begin_n = OFF_W'(pos_q);
						url_len_n   = POS_W'(1);
						qseen_n     = (rx_byte == CH_QMARK);
						qoff_n      = '0;
						slash_n     = (rx_byte == CH_SLASH);
						phase_n     = PH_URL;
					end
				end
				PH_URL: begin
					if (ws) begin
						phase_n = PH_SP2;
					end else begin
						if (rx_byte == CH_QMARK && !qseen_n) begin
							qseen_n = 1'b1;
							qoff_n  = url_len_n;
						end
						url_len_n = url_len_n + POS_W'(1);
					end
				end
				PH_SP2: begin
					if (!ws) begin
						proto_begin_n = OFF_W'(pos_q);
						proto_len_n   = POS_W'(1);
						phase_n       = PH_PROTO;
					end
				end
				PH_PROTO: begin
					if (ws) begin
						phase_n = PH_REST;
					end else begin
						proto_len_n = proto_len_n + POS_W'(1);
					end
				end
				default: ;
			endcase
		end
	end

	// outputs
	always_comb begin
		ovf  = (pos_q >= POS_W'(HEADER_BYTES));
		done = (ed_n == ED_DONE);
		res  = ovf || done;

		snap.ovf         = ovf;
		snap.method      = method_n;
		snap.phase       = phase_n;
		snap.url_begin   = url_begin_n;
		snap.url_len     = url_len_n;
		snap.slash       = slash_n;
		snap.qseen       = qseen_n;
		snap.qoff        = qoff_n;
		snap.proto_begin = proto_begin_n;
		snap.proto_len   = proto_len_n;
		snap.hlen        = HLEN_W'(pos_q + POS_W'(1));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q         <= '0;
			phase_q       <= PH_METHOD;
			cand_q        <= '1;
			method_q      <= M_UNKNOWN;
			ed_q          <= ED_IDLE;
			url_begin_q   <= '0;
			url_len_q     <= '0;
			slash_q       <= 1'b0;
			qseen_q       <= 1'b0;
			qoff_q        <= '0;
			proto_begin_q <= '0;
			proto_len_q   <= '0;
		end else if (take) begin
			if (res) begin
				pos_q         <= '0;
				phase_q       <= PH_METHOD;
				cand_q        <= '1;
				method_q      <= M_UNKNOWN;
				ed_q          <= ED_IDLE;
				url_begin_q   <= '0;
				url_len_q     <= '0;
				slash_q       <= 1'b0;
				qseen_q       <= 1'b0;
				qoff_q        <= '0;
				proto_begin_q <= '0;
				proto_len_q   <= '0;
			end else begin
				pos_q         <= pos_q + POS_W'(1);
				phase_q       <= phase_n;
				cand_q        <= cand_n;
				method_q      <= method_n;
				ed_q          <= ed_n;
				url_begin_q   <= url_begin_n;
				url_len_q     <= url_len_n;
				slash_q       <= slash_n;
				qseen_q       <= qseen_n;
				qoff_q        <= qoff_n;
				proto_begin_q <= proto_begin_n;
				proto_len_q   <= proto_len_n;
			end
		end
	end

endmodule

`default_nettype wire

>>> hw/rtl/hrlp_emit.sv
// result formatter: query split, slash strip and the output register
// uses hrlp_pkg for the snapshot type
`timescale 1ns / 1ps
`default_nettype none

module hrlp_emit (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           valid_s1,
	input  hrlp_pkg::hrlp_snap_t           snap_s1,
	input  logic                           out_stall,
	output logic                           s1_move,
	output logic                           out_valid,
	output logic [3:0]                     method,
	output logic [hrlp_pkg::OFF_W-1:0]     path_start,
	output logic [hrlp_pkg::OFF_W-1:0]     path_len,
	output logic                           root_request,
	output logic                           has_query,
	output logic [hrlp_pkg::OFF_W-1:0]     query_start,
	output logic [hrlp_pkg::OFF_W-1:0]     query_len,
	output logic [hrlp_pkg::OFF_W-1:0]     proto_start,
	output logic [hrlp_pkg::OFF_W-1:0]     proto_len,
	output logic [hrlp_pkg::HLEN_W-1:0]    header_len,
	output logic                           overflow
);
	import hrlp_pkg::*;

	logic [OFF_W-1:0]  ub, ps, qs, prs;
	logic [POS_W-1:0]  ul, pl, ql, prl;
	logic [POS_W:0]    qend;
	logic              slash, root, hq, split_m, strip_m, no_url;

	logic              out_valid_q;
	logic [3:0]        method_q;
	logic [OFF_W-1:0]  path_start_q, path_len_q, query_start_q, query_len_q;
	logic [OFF_W-1:0]  proto_start_q, proto_len_q;
	logic              root_q, hq_q, ovf_q;
	logic [HLEN_W-1:0] hlen_q;

	always_comb begin
		no_url  = (snap_s1.phase == PH_SP1);
		ub      = no_url ? OFF_W'(snap_s1.hlen) : snap_s1.url_begin;
		ul      = no_url ? '0 : snap_s1.url_len;
		slash   = no_url ? 1'b0 : snap_s1.slash;
		if (snap_s1.phase == PH_SP1 || snap_s1.phase == PH_SP2) begin
			prs = OFF_W'(snap_s1.hlen);
			prl = '0;
		end else begin
			prs = snap_s1.proto_begin;
			prl = snap_s1.proto_len;
		end

		split_m = (snap_s1.method == M_GET) || (snap_s1.method == M_UNKNOWN);
		strip_m = split_m || (snap_s1.method == M_POST);
		qend    = {1'b0, snap_s1.qoff} + (POS_W+1)'(1);

		ps   = ub;
		pl   = ul;
		hq   = 1'b0;
		qs   = '0;
		ql   = '0;
		root = 1'b0;
		if (split_m && snap_s1.qseen && !no_url) begin
			if (qend < {1'b0, ul}) begin
				hq = 1'b1;
				qs = ub + OFF_W'(qend);
				ql = ul - POS_W'(qend);
			end
			pl = snap_s1.qoff;
		end
		if (strip_m && slash) begin
			if (pl == POS_W'(1)) begin
				root = 1'b1;
				ps   = ub + OFF_W'(1);
				pl   = '0;
			end else if (pl > POS_W'(1)) begin
				ps = ub + OFF_W'(1);
				pl = pl - POS_W'(1);
			end
		end
	end

	assign s1_move = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_move) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_move && valid_s1) begin
			if (snap_s1.ovf) begin
				method_q      <= '0;
				path_start_q  <= '0;
				path_len_q    <= '0;
				root_q        <= 1'b0;
				hq_q          <= 1'b0;
				query_start_q <= '0;
				query_len_q   <= '0;
				proto_start_q <= '0;
				proto_len_q   <= '0;
				hlen_q        <= '0;
				ovf_q         <= 1'b1;
			end else begin
				method_q      <= snap_s1.method;
				path_start_q  <= ps;
				path_len_q    <= OFF_W'(pl);
				root_q        <= root;
				hq_q          <= hq;
				query_start_q <= qs;
				query_len_q   <= OFF_W'(ql);
				proto_start_q <= prs;
				proto_len_q   <= OFF_W'(prl);
				hlen_q        <= snap_s1.hlen;
				ovf_q         <= 1'b0;
			end
		end
	end

	assign out_valid    = out_valid_q;
	assign method       = method_q;
	assign path_start   = path_start_q;
	assign path_len     = path_len_q;
	assign root_request = root_q;
	assign has_query    = hq_q;
	assign query_start  = query_start_q;
	assign query_len    = query_len_q;
	assign proto_start  = proto_start_q;
	assign proto_len    = proto_len_q;
	assign header_len   = hlen_q;
	assign overflow     = ovf_q;

endmodule

`default_nettype wire

>>> hw/rtl/http_request_line_parser_top.sv
// channel  | handshake            | payload
// input    | in_valid / in_stall  | rx_byte
// output   | out_valid / out_stall| method .. overflow
//
// one byte per cycle while in_stall is low; the result for the byte that ends the header
// is registered first in the result snapshot stage and then in the formatter output register
// reset clears the parse state, the snapshot valid flag and the output valid
// in_stall rises only while a result waits in the snapshot stage behind a stalled output
// top level of the request line parser; uses hrlp_pkg, hrlp_parser, hrlp_emit
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module http_request_line_parser_top (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [7:0]                  rx_byte,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [3:0]                  method,
	output logic [hrlp_pkg::OFF_W-1:0]  path_start,
	output logic [hrlp_pkg::OFF_W-1:0]  path_len,
	output logic                        root_request,
	output logic                        has_query,
	output logic [hrlp_pkg::OFF_W-1:0]  query_start,
	output logic [hrlp_pkg::OFF_W-1:0]  query_len,
	output logic [hrlp_pkg::OFF_W-1:0]  proto_start,
	output logic [hrlp_pkg::OFF_W-1:0]  proto_len,
	output logic [hrlp_pkg::HLEN_W-1:0] header_len,
	output logic                        overflow
);
	import hrlp_pkg::*;

	logic       take, res, s1_move, valid_s1;
	hrlp_snap_t snap, snap_s1;

	assign in_stall = valid_s1 && !s1_move;
	assign take     = in_valid && !in_stall;

	hrlp_parser u_parser (
		.clk     (clk),
		.arst_n  (arst_n),
		.take    (take),
		.rx_byte (rx_byte),
		.res     (res),
		.snap    (snap)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take && res) begin
			valid_s1 <= 1'b1;
		end else if (s1_move) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take && res) begin
			snap_s1 <= snap;
		end
	end

	hrlp_emit u_emit (
		.clk          (clk),
		.arst_n       (arst_n),
		.valid_s1     (valid_s1),
		.snap_s1      (snap_s1),
		.out_stall    (out_stall),
		.s1_move      (s1_move),
		.out_valid    (out_valid),
		.method       (method),
		.path_start   (path_start),
		.path_len     (path_len),
		.root_request (root_request),
		.has_query    (has_query),
		.query_start  (query_start),
		.query_len    (query_len),
		.proto_start  (proto_start),
		.proto_len    (proto_len),
		.header_len   (header_len),
		.overflow     (overflow)
	);

	`HRLP_ASSERT_IMP(a_ovf_clean, out_valid && overflow, header_len == '0 && method == '0)
	`HRLP_ASSERT_IMP(a_hlen_min, out_valid && !overflow, header_len >= HLEN_W'(4))
	`HRLP_ASSERT_IMP(a_root_empty, out_valid && root_request, path_len == '0)
	`HRLP_ASSERT_IMP(a_query_len, out_valid && has_query, query_len != '0)

endmodule

`default_nettype wire
